FILE: rtl/tks_pkg.sv
// ============================================================================
// tks_pkg
// Shared sizes, codes and controller/datapath signal groups for the
// topological sort unit.
// ============================================================================
`default_nettype none

package tks_pkg;

  // Graph sizing.
  localparam int MAX_NODES = 16;
  localparam int MULT_BITS = 4;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int PEND_W    = 8;
  localparam int MASK_W    = 16;
  localparam int MASK_N    = (MAX_NODES < MASK_W) ? MAX_NODES : MASK_W;
  localparam int ROW_W     = MAX_NODES * MULT_BITS;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;

  // Saturation limits of the edge and pending counters.
  localparam logic [MULT_BITS-1:0] MULT_MAX = '1;
  localparam logic [PEND_W-1:0]    PEND_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_RUN   = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ORDER     = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_CYCLE     = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load_edge;
    logic flag_bad;
    logic edge_read;
    logic flag_ovf;
    logic edge_commit;
    logic run_init;
    logic scan_step;
    logic pop;
    logic relax_step;
    logic emit_order;
    logic emit_single;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_bad;
    logic edge_ovf;
    logic has_error;
    logic n_zero;
    logic scan_last;
    logic fifo_empty;
    logic all_sorted;
    logic relax_last;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/tks_ifs.sv
// ============================================================================
// tks_ifs
// Valid/ready channel interfaces for request and result words.
// ============================================================================
`default_nettype none

interface tks_req_if;
  logic                      valid;
  logic                      ready;
  logic [tks_pkg::OP_W-1:0]  opcode;
  logic [tks_pkg::CNT_W-1:0] node_total;
  logic [tks_pkg::IDX_W-1:0] dependent_node;
  logic [tks_pkg::IDX_W-1:0] dependency_node;

  modport source(output valid, opcode, node_total, dependent_node, dependency_node,
                 input ready);
  modport sink(input valid, opcode, node_total, dependent_node, dependency_node,
               output ready);
endinterface

interface tks_res_if;
  logic                         valid;
  logic                         ready;
  logic [tks_pkg::STATUS_W-1:0] status;
  logic [tks_pkg::IDX_W-1:0]    node_index;
  logic [tks_pkg::MASK_W-1:0]   blocked_mask;
  logic                         last_result;

  modport source(output valid, status, node_index, blocked_mask, last_result,
                 input ready);
  modport sink(input valid, status, node_index, blocked_mask, last_result,
               output ready);
endinterface

`default_nettype wire

FILE: rtl/topological_sort_kahn_unit.sv
// ============================================================================
// topological_sort_kahn_unit
// Loads a dependency graph and sorts it with Kahn's algorithm, emitting the
// sorted node indices or a single status word.
// ============================================================================
//
//   Channel   Role     Word contents
//   request   sink     opcode, node_total, dependent_node, dependency_node
//   result    source   status, node_index, blocked_mask, last_result
//
// A clear word is done on acceptance, an edge word passes check, row read and
// row write (the check alone when an index is out of range), and a run with an
// error or no nodes goes straight to one status word. Otherwise a run scans the
// n nodes, pops each ready node and walks its row, then emits n words or one.
// Reset is synchronous; row valid bits stand in for clearing the RAM, so words
// are accepted in the cycle after reset. A stalled result sink holds emission,
// and requests wait until a run has placed its last word in the result register.
// ============================================================================
`default_nettype none

module topological_sort_kahn_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  tks_req_if.sink    request,
  tks_res_if.source  result
);

  tks_pkg::cmd_t cmd;
  tks_pkg::sts_t sts;

  tks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_opcode(request.opcode),
    .req_ready (request.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tks_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .req_node_total     (request.node_total),
    .req_dependent_node (request.dependent_node),
    .req_dependency_node(request.dependency_node),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .res_status         (result.status),
    .res_node_index     (result.node_index),
    .res_blocked_mask   (result.blocked_mask),
    .res_last_result    (result.last_result)
  );

endmodule

`default_nettype wire

FILE: rtl/tks_ram.sv
// ============================================================================
// tks_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module tks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tks_ctrl.sv
// ============================================================================
// tks_ctrl
// Sequencer for the topological sort unit: dispatches request words and
// steps the datapath through edge updates, the sort and result emission.
// ============================================================================
`default_nettype none

module tks_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  input  wire logic [tks_pkg::OP_W-1:0] req_opcode,
  output logic                          req_ready,
  input  wire tks_pkg::sts_t            sts,
  output tks_pkg::cmd_t                 cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_CHK,
    S_EDGE_UPD,
    S_SCAN,
    S_POP,
    S_RELAX,
    S_EMIT_ORDER,
    S_EMIT_ONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (tks_pkg::opcode_t'(req_opcode))
            tks_pkg::OP_CLEAR: cmd.clear = 1'b1;
            tks_pkg::OP_EDGE: begin
              cmd.load_edge = 1'b1;
              state_next    = S_EDGE_CHK;
            end
            tks_pkg::OP_RUN: begin
              if (sts.has_error || sts.n_zero) begin
                state_next = S_EMIT_ONE;
              end else begin
                cmd.run_init = 1'b1;
                state_next   = S_SCAN;
              end
            end
            tks_pkg::OP_NOP: ;
            default: ;
          endcase
        end
      end
      S_EDGE_CHK: begin
        if (sts.edge_bad) begin
          cmd.flag_bad = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.edge_read = 1'b1;
          state_next    = S_EDGE_UPD;
        end
      end
      S_EDGE_UPD: begin
        if (sts.edge_ovf) begin
          cmd.flag_ovf = 1'b1;
        end else begin
          cmd.edge_commit = 1'b1;
        end
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (sts.fifo_empty) begin
          state_next = sts.all_sorted ? S_EMIT_ORDER : S_EMIT_ONE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_RELAX;
        end
      end
      S_RELAX: begin
        cmd.relax_step = 1'b1;
        if (sts.relax_last) begin
          state_next = S_POP;
        end
      end
      S_EMIT_ORDER: begin
        if (sts.out_free) begin
          cmd.emit_order = 1'b1;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT_ONE: begin
        if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tks_datapath.sv
// ============================================================================
// tks_datapath
// Graph storage, pending counters, ready FIFO and result register of the
// topological sort unit.
// ============================================================================
`default_nettype none

module tks_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tks_pkg::cmd_t                cmd,
  output tks_pkg::sts_t                     sts,
  input  wire logic [tks_pkg::CNT_W-1:0]    req_node_total,
  input  wire logic [tks_pkg::IDX_W-1:0]    req_dependent_node,
  input  wire logic [tks_pkg::IDX_W-1:0]    req_dependency_node,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic [tks_pkg::STATUS_W-1:0]      res_status,
  output logic [tks_pkg::IDX_W-1:0]         res_node_index,
  output logic [tks_pkg::MASK_W-1:0]        res_blocked_mask,
  output logic                              res_last_result
);

  localparam int IDX_W  = tks_pkg::IDX_W;
  localparam int CNT_W  = tks_pkg::CNT_W;
  localparam int PEND_W = tks_pkg::PEND_W;
  localparam int MB     = tks_pkg::MULT_BITS;
  localparam int NN     = tks_pkg::MAX_NODES;

  // Graph state.
  logic [CNT_W-1:0]            node_count;
  logic                        err_bad;
  logic                        err_ovf;
  logic [NN-1:0]               row_valid;
  logic [PEND_W-1:0]           pending [NN];

  // Sort scratch.
  logic [PEND_W-1:0]           work [NN];
  logic [IDX_W-1:0]            ready_fifo [NN];
  logic [CNT_W-1:0]            head;
  logic [CNT_W-1:0]            tail;
  logic [IDX_W-1:0]            scan_idx;
  logic [IDX_W-1:0]            relax_idx;
  logic [IDX_W-1:0]            emit_idx;

  // Edge word and row read state.
  logic [IDX_W-1:0]            dep_q;
  logic [IDX_W-1:0]            first_q;
  logic                        row_hit;

  // RAM ports.
  logic                        ram_we;
  logic                        ram_re;
  logic [IDX_W-1:0]            ram_raddr;
  logic [tks_pkg::ROW_W-1:0]   ram_rdata;
  logic [tks_pkg::ROW_W-1:0]   base_row;
  logic [tks_pkg::ROW_W-1:0]   new_row;

  // Derived values.
  logic [IDX_W-1:0]            n_m1;
  logic [MB-1:0]               edge_mult;
  logic [MB-1:0]               relax_mult;
  logic [PEND_W-1:0]           relax_work;
  logic [PEND_W-1:0]           relax_new;
  logic                        fifo_room;
  logic                        push_en;
  logic [IDX_W-1:0]            push_node;
  logic [tks_pkg::MASK_W-1:0]  cycle_mask;
  logic                        out_free;
  tks_pkg::status_code_t       single_code;

  tks_ram #(
    .WIDTH(tks_pkg::ROW_W),
    .DEPTH(NN)
  ) u_adj_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(first_q),
    .wdata(new_row),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign n_m1      = IDX_W'(node_count - CNT_W'(1));
  assign fifo_room = (tail < CNT_W'(NN));
  assign out_free  = !res_valid || res_ready;

  // Row reads: the edge row during an edge update, the popped node's row in a sort.
  assign ram_re    = cmd.edge_read || cmd.pop;
  assign ram_raddr = cmd.pop ? ready_fifo[head[IDX_W-1:0]] : first_q;
  assign ram_we    = cmd.edge_commit;

  // A row never written since the last clear reads as all zero.
  assign base_row  = row_hit ? ram_rdata : '0;
  assign edge_mult = base_row[dep_q*MB +: MB];

  always_comb begin
    new_row                  = base_row;
    new_row[dep_q*MB +: MB]  = edge_mult + MB'(1);
  end

  // Release of one dependent by the popped node.
  assign relax_mult = base_row[relax_idx*MB +: MB];
  assign relax_work = work[relax_idx];
  assign relax_new  = (relax_work > PEND_W'(relax_mult)) ?
                      relax_work - PEND_W'(relax_mult) : '0;

  // FIFO push source: the initial scan or a released dependent.
  always_comb begin
    push_en   = 1'b0;
    push_node = scan_idx;
    if (cmd.scan_step) begin
      push_en   = (work[scan_idx] == '0) && fifo_room;
    end else if (cmd.relax_step) begin
      push_node = relax_idx;
      push_en   = (relax_mult != '0) && (relax_work != '0) &&
                  (relax_new == '0) && fifo_room;
    end
  end

  // Nodes still blocked after a sort.
  always_comb begin
    cycle_mask = '0;
    for (int b = 0; b < tks_pkg::MASK_N; b++) begin
      cycle_mask[b] = (work[b] != '0);
    end
  end

  // Status code of a run that yields one result.
  always_comb begin
    priority if (err_bad) begin
      single_code = tks_pkg::ST_BAD_INDEX;
    end else if (err_ovf) begin
      single_code = tks_pkg::ST_OVERFLOW;
    end else if (node_count == '0) begin
      single_code = tks_pkg::ST_EMPTY;
    end else begin
      single_code = tks_pkg::ST_CYCLE;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.edge_bad   = (CNT_W'(dep_q) >= node_count) || (CNT_W'(first_q) >= node_count);
    sts.edge_ovf   = (edge_mult == tks_pkg::MULT_MAX) || (pending[dep_q] == tks_pkg::PEND_MAX);
    sts.has_error  = err_bad || err_ovf;
    sts.n_zero     = (node_count == '0);
    sts.scan_last  = (scan_idx == n_m1);
    sts.fifo_empty = (head == tail);
    sts.all_sorted = (tail == node_count);
    sts.relax_last = (relax_idx == n_m1);
    sts.emit_last  = (emit_idx == n_m1);
    sts.out_free   = out_free;
  end

  // Control state: graph size, flags, row valid bits, counters, pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      err_bad    <= 1'b0;
      err_ovf    <= 1'b0;
      row_valid  <= '0;
      head       <= '0;
      tail       <= '0;
      scan_idx   <= '0;
      relax_idx  <= '0;
      emit_idx   <= '0;
      res_valid  <= 1'b0;
      for (int n = 0; n < NN; n++) begin
        pending[n] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        row_valid <= '0;
        head      <= '0;
        tail      <= '0;
        err_ovf   <= 1'b0;
        for (int n = 0; n < NN; n++) begin
          pending[n] <= '0;
        end
        if (req_node_total > CNT_W'(NN)) begin
          node_count <= '0;
          err_bad    <= 1'b1;
        end else begin
          node_count <= req_node_total;
          err_bad    <= 1'b0;
        end
      end
      if (cmd.flag_bad) begin
        err_bad <= 1'b1;
      end
      if (cmd.flag_ovf) begin
        err_ovf <= 1'b1;
      end
      if (cmd.edge_commit) begin
        row_valid[first_q] <= 1'b1;
        pending[dep_q]     <= pending[dep_q] + PEND_W'(1);
      end
      if (cmd.run_init) begin
        head     <= '0;
        tail     <= '0;
        scan_idx <= '0;
        emit_idx <= '0;
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.pop) begin
        head      <= head + CNT_W'(1);
        relax_idx <= '0;
      end
      if (cmd.relax_step) begin
        relax_idx <= relax_idx + IDX_W'(1);
      end
      if (push_en) begin
        tail <= tail + CNT_W'(1);
      end
      if (cmd.emit_order) begin
        emit_idx <= emit_idx + IDX_W'(1);
      end
      // Result register: loads a word or drains when the sink takes it.
      if (cmd.emit_order || cmd.emit_single) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_edge) begin
      dep_q   <= req_dependent_node;
      first_q <= req_dependency_node;
    end
    if (ram_re) begin
      row_hit <= row_valid[ram_raddr];
    end
    if (cmd.run_init) begin
      for (int n = 0; n < NN; n++) begin
        work[n] <= pending[n];
      end
    end
    if (cmd.relax_step && (relax_mult != '0) && (relax_work != '0)) begin
      work[relax_idx] <= relax_new;
    end
    if (push_en) begin
      ready_fifo[tail[IDX_W-1:0]] <= push_node;
    end
    if (cmd.emit_order) begin
      res_status       <= tks_pkg::ST_ORDER;
      res_node_index   <= ready_fifo[emit_idx];
      res_blocked_mask <= '0;
      res_last_result  <= (emit_idx == n_m1);
    end else if (cmd.emit_single) begin
      res_status       <= single_code;
      res_node_index   <= '0;
      res_blocked_mask <= (single_code == tks_pkg::ST_CYCLE) ? cycle_mask : '0;
      res_last_result  <= 1'b1;
    end
  end

  // The ready FIFO never runs ahead of its writes nor past the node count.
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail) else $error("ready FIFO head passed tail");

  a_tail_le_count: assert property (@(posedge clk) disable iff (rst)
    tail <= node_count) else $error("ready FIFO holds more nodes than the graph");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (head != tail)) else $error("pop issued on empty ready FIFO");

  a_commit_no_ovf: assert property (@(posedge clk) disable iff (rst)
    cmd.edge_commit |-> !sts.edge_ovf) else $error("edge stored into a full counter");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_order || cmd.emit_single) |-> out_free)
    else $error("result word overwritten before it was taken");

endmodule

`default_nettype wire
